[rtl/core/soai_pkg.sv]
`default_nettype none
package soai_pkg;
    localparam int unsigned CordicStagesDef = 16;
    localparam int unsigned CordicMax = 24;
    localparam int unsigned AccW = 56;
    localparam int unsigned SumW = 64;
    localparam int unsigned OutW = 63;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 16;
    localparam logic [CfgIdxW-1:0] RegSolvation = 1'd0;
    localparam logic [CfgIdxW-1:0] RegVectorCount = 1'd1;
    localparam logic signed [20:0] TurnScale = 21'sd667544;
    localparam logic signed [33:0] CordicX0 = 34'sd652032874;

    // atan table in 2^-32 turn units
    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0: r = 34'sd536870912;   5'd1: r = 34'sd316933406;
            5'd2: r = 34'sd167458907;   5'd3: r = 34'sd85004756;
            5'd4: r = 34'sd42667331;    5'd5: r = 34'sd21354465;
            5'd6: r = 34'sd10680862;    5'd7: r = 34'sd5340245;
            5'd8: r = 34'sd2670163;     5'd9: r = 34'sd1335087;
            5'd10: r = 34'sd667544;     5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;     5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;      5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;      5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;       5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;        5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;        5'd23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    // one classified atom: corrected factor, angle, end marker
    typedef struct packed {
        logic signed [32:0] f;
        logic [31:0]        angle;
        logic               last;
    } t_atom;

    typedef struct packed {
        logic [OutW-1:0] intensity;
        logic [15:0]     point_index;
    } t_result;
endpackage
`default_nettype wire

[rtl/core/soai_if.sv]
`default_nettype none
interface soai_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        q_value;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic [19:0]        vac_factor;
    logic [19:0]        excl_factor;
    logic [15:0]        surface_area;
    logic signed [19:0] solvent_ff;
    logic               last_atom;
    modport source (output valid, dir_x, dir_y, dir_z, q_value, pos_x, pos_y, pos_z,
                    vac_factor, excl_factor, surface_area, solvent_ff, last_atom,
                    input ready);
    modport sink (input valid, dir_x, dir_y, dir_z, q_value, pos_x, pos_y, pos_z,
                  vac_factor, excl_factor, surface_area, solvent_ff, last_atom,
                  output ready);
endinterface

interface soai_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] intensity;
    logic [15:0] point_index;
    modport source (output valid, intensity, point_index, input ready);
    modport sink (input valid, intensity, point_index, output ready);
endinterface
`default_nettype wire

[rtl/core/soai_front.sv]
`default_nettype none
// accepts atoms, computes corrected form factor and phase angle over a short pipeline
module soai_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic signed [15:0]    i_solvation,
    soai_in_if.sink                    in_ch,
    output soai_pkg::t_atom            o_atom,
    output logic                       o_valid,
    input  wire logic                  i_ready
);
    import soai_pkg::*;

    // stage valids and stall
    logic [2:0] r_v;
    logic       adv;
    assign adv = !r_v[2] || i_ready;
    assign in_ch.ready = adv;

    // stage 1: products
    logic signed [35:0] r_ax, r_ay, r_az;
    logic signed [32:0] r_ahs;
    logic signed [19:0] r_solv1;
    logic signed [20:0] r_vd1;
    logic [15:0]        r_q1;
    logic               r_l1;
    // stage 2: sums and second products
    logic signed [54:0] r_pq;
    logic signed [52:0] r_hp;
    logic signed [20:0] r_vd2;
    logic               r_l2;
    // stage 3
    logic signed [32:0] r_f;
    logic [31:0]        r_ang;
    logic               r_l3;

    logic signed [37:0] dot;
    logic signed [54:0] ph;
    logic signed [54:0] ph_r;
    logic signed [75:0] turn;
    logic signed [52:0] hy;
    assign dot = 38'(r_ax) + 38'(r_ay) + 38'(r_az);
    assign ph = r_pq + 55'sd1024;
    assign ph_r = ph >>> 11;
    assign turn = 76'(ph_r) * 76'(TurnScale);
    assign hy = (r_hp + 53'sd524288) >>> 20;

    // validity pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[1:0], in_ch.valid};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ax <= in_ch.dir_x * in_ch.pos_x;
            r_ay <= in_ch.dir_y * in_ch.pos_y;
            r_az <= in_ch.dir_z * in_ch.pos_z;
            r_ahs <= $signed({1'b0, in_ch.surface_area}) * i_solvation;
            r_solv1 <= in_ch.solvent_ff;
            r_vd1 <= $signed({1'b0, in_ch.vac_factor}) - $signed({1'b0, in_ch.excl_factor});
            r_q1 <= in_ch.q_value;
            r_l1 <= in_ch.last_atom;
            r_pq <= 55'(dot * $signed({1'b0, r_q1}));
            r_hp <= 53'(r_ahs * r_solv1);
            r_vd2 <= r_vd1;
            r_l2 <= r_l1;
            r_f <= 33'(r_vd2) + 33'(hy);
            r_ang <= turn[45:14];
            r_l3 <= r_l2;
        end
    end

    assign o_valid = r_v[2];
    assign o_atom.f = r_f;
    assign o_atom.angle = r_ang;
    assign o_atom.last = r_l3;
endmodule
`default_nettype wire

[rtl/core/soai_queue.sv]
`default_nettype none
// small fifo between front and back
module soai_queue #(
    parameter int unsigned Depth = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  soai_pkg::t_atom     i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output soai_pkg::t_atom     o_data
);
    import soai_pkg::*;
    localparam int unsigned AW = $clog2(Depth);
    t_atom r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic wr, rd;
    assign o_ready = r_cnt != (AW+1)'(Depth);
    assign o_valid = r_cnt != '0;
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    assign o_data = r_mem[r_rp];

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(Depth-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(Depth-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

[rtl/core/soai_back.sv]
`default_nettype none
// cordic, accumulation, magnitude and averaging, one atom at a time
module soai_back #(
    parameter int unsigned CordicStages = soai_pkg::CordicStagesDef
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [15:0]    i_vector_count,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  soai_pkg::t_atom     i_atom,
    soai_out_if.source          out_ch
);
    import soai_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_ROT = 8'b00000010, S_MUL = 8'b00000100,
        S_ACC = 8'b00001000, S_SQ = 8'b00010000, S_ISUM = 8'b00100000,
        S_DIV = 8'b01000000, S_OUT = 8'b10000000
    } t_state;

    t_state r_st;
    logic [4:0] r_i;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [32:0] r_f;
    logic r_flip, r_last;
    logic signed [66:0] r_pc, r_ps;
    logic signed [AccW-1:0] r_cs, r_ss;
    logic [SumW-1:0] r_sq, r_isum;
    logic r_sat;
    logic [15:0] r_dd, r_pt;
    // divider
    logic [SumW-1:0] r_quo, r_rem;
    logic [6:0] r_dc;
    logic [15:0] r_vc;
    logic r_ov;
    logic [OutW-1:0] r_oi;
    logic [15:0] r_op;

    logic [31:0] fa;
    logic signed [33:0] dxs, dys, at;
    logic signed [66:0] rc, rs;
    logic signed [AccW:0] nc, ns;
    logic [31:0] mc, ms;
    logic bigc, bigs;
    logic [64:0] ssum, isum;
    logic [64:0] trem;
    logic [15:0] dd1;

    assign fa = i_atom.angle ^ ((i_atom.angle + 32'h40000000) & 32'h80000000);
    assign dxs = r_y >>> r_i;
    assign dys = r_x >>> r_i;
    assign at = atan_turn(r_i);
    assign rc = (r_pc + 67'sd536870912) >>> 30;
    assign rs = (r_ps + 67'sd536870912) >>> 30;
    assign nc = (AccW+1)'(r_cs) + (AccW+1)'(rc);
    assign ns = (AccW+1)'(r_ss) + (AccW+1)'(rs);
    assign bigc = (r_cs[AccW-1] ? -r_cs : r_cs) >= (AccW)'(64'h1_0000_0000);
    assign bigs = (r_ss[AccW-1] ? -r_ss : r_ss) >= (AccW)'(64'h1_0000_0000);
    assign mc = r_cs[AccW-1] ? 32'(-r_cs) : r_cs[31:0];
    assign ms = r_ss[AccW-1] ? 32'(-r_ss) : r_ss[31:0];
    assign ssum = 65'(r_sq) + 65'(ms * ms);
    assign isum = 65'(r_isum) + 65'(r_sq);
    assign trem = {r_rem, r_quo[SumW-1]};
    assign dd1 = r_dd + 16'd1;

    assign o_ready = r_st == S_IDLE;
    assign out_ch.valid = r_ov;
    assign out_ch.intensity = r_oi;
    assign out_ch.point_index = r_op;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cs <= '0; r_ss <= '0; r_isum <= '0;
            r_dd <= '0; r_pt <= '0; r_ov <= 1'b0;
        end else begin
            // the result state reloads the output register itself
            if (out_ch.valid && out_ch.ready && r_st != S_OUT) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_flip <= fa != i_atom.angle;
                        r_z <= 34'($signed(fa));
                        r_x <= CordicX0; r_y <= '0; r_i <= '0;
                        r_f <= i_atom.f; r_last <= i_atom.last;
                        r_st <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - dxs; r_y <= r_y + dys; r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + dxs; r_y <= r_y - dys; r_z <= r_z + at;
                    end
                    r_i <= r_i + 5'd1;
                    if (32'(r_i) == CordicStages - 1) r_st <= S_MUL;
                end
                S_MUL: begin
                    r_pc <= 67'(r_f) * 67'(r_flip ? -r_x : r_x);
                    r_ps <= 67'(r_f) * 67'(r_flip ? -r_y : r_y);
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    r_cs <= (nc[AccW] != nc[AccW-1]) ?
                        {nc[AccW], {(AccW-1){!nc[AccW]}}} : nc[AccW-1:0];
                    r_ss <= (ns[AccW] != ns[AccW-1]) ?
                        {ns[AccW], {(AccW-1){!ns[AccW]}}} : ns[AccW-1:0];
                    r_st <= r_last ? S_SQ : S_IDLE;
                    r_sat <= 1'b0;
                end
                S_SQ: begin
                    // squares cos first, then sin
                    if (!r_sat) begin
                        r_sq <= 64'(mc * mc); r_sat <= 1'b1;
                    end else begin
                        r_sq <= (bigc || bigs || ssum[64]) ? '1 : ssum[63:0];
                        r_st <= S_ISUM;
                    end
                end
                S_ISUM: begin
                    r_cs <= '0; r_ss <= '0;
                    r_dd <= dd1;
                    r_vc <= (i_vector_count == '0) ? 16'd1 : i_vector_count;
                    if (dd1 >= ((i_vector_count == '0) ? 16'd1 : i_vector_count)) begin
                        r_quo <= isum[64] ? '1 : isum[63:0];
                        r_rem <= '0; r_dc <= '0;
                        r_st <= S_DIV;
                    end else begin
                        r_isum <= isum[64] ? '1 : isum[63:0];
                        r_st <= S_IDLE;
                    end
                end
                S_DIV: begin
                    // restoring division, one bit a cycle
                    if (trem >= 65'(r_vc)) begin
                        r_rem <= 64'(trem - 65'(r_vc));
                        r_quo <= {r_quo[SumW-2:0], 1'b1};
                    end else begin
                        r_rem <= trem[63:0];
                        r_quo <= {r_quo[SumW-2:0], 1'b0};
                    end
                    r_dc <= r_dc + 7'd1;
                    if (r_dc == 7'd63) r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || out_ch.ready) begin
                        r_ov <= 1'b1;
                        r_oi <= r_quo[63] ? '1 : r_quo[OutW-1:0];
                        r_op <= r_pt;
                        r_pt <= r_pt + 16'd1;
                        r_isum <= '0; r_dd <= '0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/saxs_orientation_averaged_intensity.sv]
`default_nettype none
// Orientation averaged scattering intensity. A front pipeline accepts one atom per cycle
// unless stalled by the queue, and forms the corrected form factor and phase angle; a
// 4-entry queue feeds a back end that runs the CORDIC as an iterative unit, one atom at
// a time, then multiplies and accumulates. The last atom of a direction adds the
// magnitude (squares and sum); the last of a q point adds the bit-serial divide by
// vector_count and the result register.
module saxs_orientation_averaged_intensity #(
    parameter int unsigned CORDIC_STAGES = soai_pkg::CordicStagesDef
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [soai_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  wire logic [soai_pkg::CfgDataW-1:0]   i_cfg_data,
    soai_in_if.sink                              in_ch,
    soai_out_if.source                           out_ch
);
    import soai_pkg::*;

    logic signed [15:0] r_solv;
    logic [15:0] r_vcount;
    t_atom fa, qa;
    logic fv, fr, qv, qr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solv <= '0; r_vcount <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegSolvation: r_solv <= i_cfg_data;
                RegVectorCount: r_vcount <= i_cfg_data;
                default: ;
            endcase
        end
    end

    soai_front u_front (.i_clk, .i_rst_n, .i_solvation(r_solv), .in_ch,
        .o_atom(fa), .o_valid(fv), .i_ready(fr));
    soai_queue #(.Depth(4)) u_queue (.i_clk, .i_rst_n, .i_valid(fv), .o_ready(fr),
        .i_data(fa), .o_valid(qv), .i_ready(qr), .o_data(qa));
    soai_back #(.CordicStages(CORDIC_STAGES)) u_back (.i_clk, .i_rst_n,
        .i_vector_count(r_vcount), .i_valid(qv), .o_ready(qr), .i_atom(qa), .out_ch);
endmodule
`default_nettype wire

[rtl/core/soai_checker.sv]
`default_nettype none
// port-level checks
module soai_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [62:0] o_int,
    input wire logic [15:0] o_pt
);
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_int) && $stable(o_pt)) else $error("hold");
    // point index advances by one between results
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid || o_pt == $past(o_pt) + 16'd1) else $error("seq");
    // no result right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid) else $error("rst");
endmodule

bind saxs_orientation_averaged_intensity soai_checker u_chk (.i_clk, .i_rst_n,
    .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_int(out_ch.intensity),
    .o_pt(out_ch.point_index));
`default_nettype wire
